/* hw/rtl/fttcop_pkg.sv */
// Shared types and constants for the force/torque tare and center-of-pressure block.
`default_nettype none

package fttcop_pkg;

  // Opcodes of an input transaction
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TARE   = 1'b1;

  // Number of force/torque channels and fixed channel slots
  localparam int NUM_CH = 6;
  localparam logic [2:0] CH_FZ = 3'd2;
  localparam logic [2:0] CH_MX = 3'd3;
  localparam logic [2:0] CH_MY = 3'd4;
  localparam logic [2:0] CH_LAST = 3'd5;

  // Signed 32-bit limits
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
    logic [15:0]        packet_number;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] tared_fx;
    logic signed [31:0] tared_fy;
    logic signed [31:0] tared_fz;
    logic signed [31:0] tared_mx;
    logic signed [31:0] tared_my;
    logic signed [31:0] tared_mz;
    logic signed [31:0] arm_x;
    logic signed [31:0] arm_y;
    logic [15:0]        packet_echo;
    logic [7:0]         sensor_echo;
  } result_t;

  // Request into the shared divider
  typedef struct packed {
    logic               start;
    logic               neg;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/force_torque_tare_center_of_pressure_core.sv */
// Top level of the force/torque tare and center-of-pressure block.
`default_nettype none

// Takes one transaction at a time: a six-axis sample or a tare command, with
// the block stalling its input until the transaction is finished. A shared
// 33-bit adder walks the six channels one per cycle (tare: offsets plus last
// tared values; sample: raw minus offsets, each saturated). For a sample with
// Fz magnitude above the threshold, the one shared restoring divider runs twice
// (arm X, then arm Y). The result sits in an output register, so the next
// transaction is accepted while it waits. min_force (byte 0) and sensor_tag
// (byte 4) are written and read over the APB port.
module force_torque_tare_center_of_pressure_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  fttcop_pkg::sample_t sample,
  output logic                result_valid,
  input  logic                result_stall,
  output fttcop_pkg::result_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fttcop_pkg::*;

  localparam logic REG_MIN_FORCE  = 1'b0;
  localparam logic REG_SENSOR_TAG = 1'b1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV_X = 3'd3;
  localparam logic [2:0] S_DIV_Y = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state;
  logic [2:0]  ch;
  logic        opcode;
  logic [15:0] packet;
  logic [30:0] min_force;
  logic [7:0]  sensor_tag;
  logic [31:0] raw       [NUM_CH];
  logic [31:0] offs      [NUM_CH];
  logic [31:0] last      [NUM_CH];
  logic [31:0] arm_x;
  logic [31:0] arm_y;

  logic [32:0] add_a;
  logic [32:0] add_b;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [31:0] fz_mag;
  logic        above;
  logic        cfg_wr;
  logic        out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_force  <= 31'd131072;
      sensor_tag <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MIN_FORCE:  min_force  <= pwdata[30:0];
        REG_SENSOR_TAG: sensor_tag <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_FORCE:  prdata = {1'b0, min_force};
      REG_SENSOR_TAG: prdata = {24'd0, sensor_tag};
      default:        prdata = '0;
    endcase
  end

  // Shared saturating adder: offset + last on tare, raw - offset on sample
  always_comb begin
    if (opcode == OP_TARE) begin
      add_a = {offs[ch][31], offs[ch]};
      add_b = {last[ch][31], last[ch]};
      sum   = add_a + add_b;
    end else begin
      add_a = {raw[ch][31], raw[ch]};
      add_b = ~{offs[ch][31], offs[ch]};
      sum   = add_a + add_b + 33'd1;
    end
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? S32_MIN : S32_MAX;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Threshold test on tared Fz
  assign fz_mag = last[CH_FZ][31] ? 32'(-last[CH_FZ]) : last[CH_FZ];
  assign above  = fz_mag > {1'b0, min_force};

  // Divider requests: arm X from My, then arm Y from negated Mx
  always_comb begin
    div_req.den   = last[CH_FZ];
    div_req.start = 1'b0;
    div_req.neg   = 1'b0;
    div_req.num   = last[CH_MY];
    if (state == S_CHECK && above) begin
      div_req.start = 1'b1;
    end else if (state == S_DIV_X && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.neg   = 1'b1;
      div_req.num   = last[CH_MX];
    end
  end

  fttcop_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign sample_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // Sequencer and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        offs[i] <= '0;
        last[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            ch    <= '0;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (opcode == OP_TARE) begin
            offs[ch] <= sum_sat;
          end else begin
            last[ch] <= sum_sat;
          end
          ch <= ch + 3'd1;
          if (ch == CH_LAST) begin
            state <= (opcode == OP_TARE) ? S_IDLE : S_CHECK;
          end
        end
        S_CHECK: begin
          state <= above ? S_DIV_X : S_OUT;
        end
        S_DIV_X: begin
          if (div_rsp.done) begin
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the transaction payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample_valid) begin
      opcode <= sample.opcode;
      packet <= sample.packet_number;
      raw[0] <= sample.force_x;
      raw[1] <= sample.force_y;
      raw[2] <= sample.force_z;
      raw[3] <= sample.moment_x;
      raw[4] <= sample.moment_y;
      raw[5] <= sample.moment_z;
    end
  end

  // Hold the moment arms
  always_ff @(posedge clk) begin
    if (state == S_CHECK && !above) begin
      arm_x <= '0;
      arm_y <= '0;
    end else if (state == S_DIV_X && div_rsp.done) begin
      arm_x <= div_rsp.quot;
    end else if (state == S_DIV_Y && div_rsp.done) begin
      arm_y <= div_rsp.quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result.tared_fx    <= last[0];
      result.tared_fy    <= last[1];
      result.tared_fz    <= last[2];
      result.tared_mx    <= last[3];
      result.tared_my    <= last[4];
      result.tared_mz    <= last[5];
      result.arm_x       <= arm_x;
      result.arm_y       <= arm_y;
      result.packet_echo <= packet;
      result.sensor_echo <= sensor_tag;
    end
  end

  // Checks
  a_accept_starts_add: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (state == S_ADD))
    else $error("accepted transaction did not start the channel pass");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");

  a_below_zero_arms: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !above) |=> (arm_x == '0 && arm_y == '0))
    else $error("arms not cleared below the force threshold");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_X || state == S_DIV_Y))
    else $error("divider finished outside a division state");

endmodule

`default_nettype wire

/* hw/rtl/fttcop_div.sv */
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated to 32 bits.
`default_nettype none

module fttcop_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fttcop_pkg::div_req_t req,
  output fttcop_pkg::div_rsp_t rsp
);
  import fttcop_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);
  localparam logic [DW-1:0] NEG_LIM = DW'(64'h8000_0000);

  logic          busy;
  logic          fin;
  logic [CW-1:0] cnt;
  logic          neg_q;
  logic [31:0]   dmag;
  logic [31:0]   rem;
  logic [DW-1:0] dq;

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        fit;

  // Operand magnitudes; the most negative value maps to 2^31
  assign num_mag = req.num[31] ? 32'(-req.num) : req.num;
  assign den_mag = req.den[31] ? 32'(-req.den) : req.den;

  // One quotient bit per cycle
  assign shifted = {rem, dq[DW-1]};
  assign diff    = shifted - {1'b0, dmag};
  assign fit     = shifted >= {1'b0, dmag};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dq    <= DW'(num_mag) << FRAC_BITS;
      rem   <= '0;
      dmag  <= den_mag;
      neg_q <= req.num[31] ^ req.den[31] ^ req.neg;
    end else if (busy) begin
      rem <= fit ? diff[31:0] : shifted[31:0];
      dq  <= {dq[DW-2:0], fit};
    end
  end

  // Apply sign and saturate the magnitude quotient
  always_comb begin
    rsp.done = fin;
    if (neg_q) begin
      rsp.quot = (dq > NEG_LIM) ? S32_MIN : 32'(-dq[31:0]);
    end else begin
      rsp.quot = (dq > POS_LIM) ? S32_MAX : dq[31:0];
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the force/torque tare and center-of-pressure core.
`timescale 1ns / 1ps

module testbench;
  import fttcop_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam longint ARM_SCALE = 64'sd1 << FRAC_BITS;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam logic [2:0] ADDR_MIN_FORCE = 3'd0;
  localparam logic [2:0] ADDR_SENSOR_TAG = 3'd4;
  localparam logic [30:0] MIN_FORCE_RESET = 31'd131072;
  localparam logic [30:0] MIN_FORCE_MAX = 31'h7FFF_FFFF;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow of the block: offsets, last tared sample and register copies
  longint tare_offsets [NUM_CH];
  longint held_tared [NUM_CH];
  logic [30:0] min_force_cfg = MIN_FORCE_RESET;
  logic [7:0] sensor_tag_cfg = 8'd0;

  sample_t pending_items [$];
  result_t expected_results [$];
  logic idle_enabled = 1'b1;
  int idle_cycles = 0;
  int failures = 0;
  int n_samples = 0;
  int n_tares = 0;
  int n_arm_samples = 0;
  int n_results = 0;

  force_torque_tare_center_of_pressure_core #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp_s32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // Update the shadow state for one accepted transaction and queue its result
  task automatic predict_transaction(input sample_t item);
    longint raw [NUM_CH];
    longint fz;
    longint mag;
    longint arm_x;
    longint arm_y;
    result_t r;
    if (item.opcode == OP_TARE) begin
      for (int i = 0; i < NUM_CH; i++)
        tare_offsets[i] = clamp_s32(tare_offsets[i] + held_tared[i]);
      n_tares++;
      return;
    end
    raw[0] = item.force_x;
    raw[1] = item.force_y;
    raw[2] = item.force_z;
    raw[3] = item.moment_x;
    raw[4] = item.moment_y;
    raw[5] = item.moment_z;
    for (int i = 0; i < NUM_CH; i++)
      held_tared[i] = clamp_s32(raw[i] - tare_offsets[i]);
    fz = held_tared[CH_FZ];
    mag = (fz < 0) ? -fz : fz;
    if (mag > longint'(min_force_cfg)) begin
      arm_x = clamp_s32((held_tared[CH_MY] * ARM_SCALE) / fz);
      arm_y = clamp_s32(-((held_tared[CH_MX] * ARM_SCALE) / fz));
      n_arm_samples++;
    end else begin
      arm_x = 0;
      arm_y = 0;
    end
    r.tared_fx = held_tared[0][31:0];
    r.tared_fy = held_tared[1][31:0];
    r.tared_fz = held_tared[2][31:0];
    r.tared_mx = held_tared[3][31:0];
    r.tared_my = held_tared[4][31:0];
    r.tared_mz = held_tared[5][31:0];
    r.arm_x = arm_x[31:0];
    r.arm_y = arm_y[31:0];
    r.packet_echo = item.packet_number;
    r.sensor_echo = sensor_tag_cfg;
    expected_results.push_back(r);
    n_samples++;
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("[%0t] %s differs: expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("[%0t] unexpected result transaction: expected none actual %h", $time, got);
      failures++;
      return;
    end
    want = expected_results.pop_front();
    n_results++;
    report_field("tared_fx", want.tared_fx, got.tared_fx);
    report_field("tared_fy", want.tared_fy, got.tared_fy);
    report_field("tared_fz", want.tared_fz, got.tared_fz);
    report_field("tared_mx", want.tared_mx, got.tared_mx);
    report_field("tared_my", want.tared_my, got.tared_my);
    report_field("tared_mz", want.tared_mz, got.tared_mz);
    report_field("arm_x", want.arm_x, got.arm_x);
    report_field("arm_y", want.arm_y, got.arm_y);
    report_field("packet_echo", 32'(want.packet_echo), 32'(got.packet_echo));
    report_field("sensor_echo", 32'(want.sensor_echo), 32'(got.sensor_echo));
  endtask

  function automatic sample_t make_sample(input logic [31:0] fx, input logic [31:0] fy,
                                          input logic [31:0] fz, input logic [31:0] mx,
                                          input logic [31:0] my, input logic [31:0] mz,
                                          input logic [15:0] pkt);
    sample_t s;
    s.opcode = OP_SAMPLE;
    s.force_x = fx;
    s.force_y = fy;
    s.force_z = fz;
    s.moment_x = mx;
    s.moment_y = my;
    s.moment_z = mz;
    s.packet_number = pkt;
    return s;
  endfunction

  // Tare with junk in every other field
  function automatic sample_t make_tare();
    sample_t s;
    logic [223:0] junk;
    junk = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom()};
    s = junk[$bits(sample_t)-1:0];
    s.opcode = OP_TARE;
    return s;
  endfunction

  function automatic logic [31:0] rand_channel();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  // Fz magnitude within a couple of LSBs of the threshold, either sign
  function automatic logic [31:0] near_threshold();
    longint v;
    v = longint'(min_force_cfg) + longint'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[31:0];
  endfunction

  // Queue sequences: a base sample, a tare onto it, then samples around that base
  task automatic add_random_items(input int count);
    int added;
    int run_len;
    sample_t base;
    added = 0;
    while (added < count) begin
      base = make_sample(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                         rand_channel(), rand_channel(), 16'($urandom()));
      pending_items.push_back(base);
      pending_items.push_back(make_tare());
      added += 2;
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(make_tare());
        added++;
      end
      run_len = $urandom_range(1, 10);
      repeat (run_len) begin
        pending_items.push_back(make_sample(
          base.force_x + rand_channel(), base.force_y + rand_channel(),
          ($urandom_range(0, 9) < 4) ? base.force_z + near_threshold()
                                     : base.force_z + rand_channel(),
          base.moment_x + rand_channel(), base.moment_y + rand_channel(),
          base.moment_z + rand_channel(), 16'($urandom())));
        added++;
      end
    end
  endtask

  // Bring the offsets back to zero: zero sample then tare, twice to clear saturation
  task automatic push_rezero();
    repeat (2) begin
      pending_items.push_back(make_sample('0, '0, '0, '0, '0, '0, 16'($urandom())));
      pending_items.push_back(make_tare());
    end
  endtask

  // Hold until all input is taken and every result is back, then let a tare finish
  task automatic wait_quiet();
    while (pending_items.size() != 0 || sample_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MIN_FORCE) min_force_cfg = value[30:0];
    else sensor_tag_cfg = value[7:0];
  endtask

  task automatic configure(input logic [30:0] min_force, input logic [7:0] tag);
    write_register(ADDR_MIN_FORCE, {1'b0, min_force});
    write_register(ADDR_SENSOR_TAG, {24'd0, tag});
    @(negedge clk);
  endtask

  // Drive input transactions from the pending queue, predicting each accepted one
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall)
        predict_transaction(sample);
      if (!sample_valid || !sample_stall) begin
        if (pending_items.size() != 0 && !(idle_enabled && $urandom_range(0, 99) < 9)) begin
          sample <= pending_items.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Check result transactions and stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall)
        check_result(result);
      result_stall <= idle_enabled && ($urandom_range(0, 99) < 9);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("force_torque_tare_center_of_pressure_core: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      tare_offsets[i] = 0;
      held_tared[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: tare before any sample, threshold edges, extremes, tare chains
    pending_items.push_back(make_tare());
    pending_items.push_back(make_sample('0, '0, '0, '0, '0, '0, 16'h0000));
    pending_items.push_back(make_sample(32'h0000_0001, 32'hFFFF_FFFF, 32'h0003_0000,
                                        32'hFFFF_4000, 32'h0001_8000, 32'h0000_0005,
                                        16'h0001));
    pending_items.push_back(make_sample('0, '0, 32'h0002_0000, 32'h0001_0000,
                                        32'h0001_0000, '0, 16'h0002));
    pending_items.push_back(make_sample('0, '0, 32'hFFFE_0000, 32'h0001_0000,
                                        32'h0001_0000, '0, 16'h0003));
    pending_items.push_back(make_sample('0, '0, 32'h0002_0001, 32'h8000_0000,
                                        32'h7FFF_FFFF, '0, 16'h0004));
    pending_items.push_back(make_sample('0, '0, 32'hFFFD_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, '0, 16'h0005));
    pending_items.push_back(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        16'hFFFF));
    pending_items.push_back(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        16'h8000));
    pending_items.push_back(make_tare());
    pending_items.push_back(make_tare());
    pending_items.push_back(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        16'h7FFF));
    pending_items.push_back(make_tare());
    pending_items.push_back(make_sample('0, '0, '0, '0, '0, '0, 16'h00A5));
    pending_items.push_back(make_tare());
    pending_items.push_back(make_sample(32'h0000_1000, 32'hFFFF_F000, 32'hFFFC_0000,
                                        32'h0003_0000, 32'hFFFD_8000, 32'h0000_0100,
                                        16'h5A5A));
    pending_items.push_back(make_sample('0, '0, '0, '0, '0, '0, 16'h1234));
    pending_items.push_back(make_tare());
    add_random_items(430);
    wait_quiet();

    // Zero threshold and full tag: arm saturation in every direction
    configure('0, 8'hFF);
    push_rezero();
    pending_items.push_back(make_sample('0, '0, 32'h0000_0001, 32'h8000_0000,
                                        32'h7FFF_FFFF, '0, 16'h0100));
    pending_items.push_back(make_sample('0, '0, 32'h0000_0001, 32'h7FFF_FFFF,
                                        32'h8000_0000, '0, 16'h0101));
    pending_items.push_back(make_sample('0, '0, 32'hFFFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, '0, 16'h0102));
    pending_items.push_back(make_sample('0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0,
                                        16'h0103));
    add_random_items(430);
    wait_quiet();

    // Maximum threshold: only the most negative Fz clears it; no idling here
    configure(MIN_FORCE_MAX, 8'h00);
    push_rezero();
    pending_items.push_back(make_sample('0, '0, 32'h8000_0000, 32'h8000_0000,
                                        32'h0001_0000, '0, 16'h0200));
    pending_items.push_back(make_sample('0, '0, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h0001_0000, '0, 16'h0201));
    idle_enabled = 1'b0;
    add_random_items(300);
    wait_quiet();
    idle_enabled = 1'b1;

    // Small random threshold, with a full drain halfway
    configure(31'($urandom_range(0, 32'h0010_0000)), 8'($urandom()));
    add_random_items(230);
    wait_quiet();
    add_random_items(230);
    wait_quiet();

    // Threshold anywhere in its range
    configure(31'($urandom()), 8'($urandom()));
    add_random_items(300);
    wait_quiet();

    $display("Covered %0d samples (%0d with moment arms) and %0d tares over five settings",
             n_samples, n_arm_samples, n_tares);
    $display("of threshold and tag; %0d results checked, %0d field errors.",
             n_results, failures);
    if (failures == 0)
      $display("force_torque_tare_center_of_pressure_core: match");
    else
      $display("force_torque_tare_center_of_pressure_core: mismatch");
    $finish;
  end

endmodule
